/* src/ascii_to_shift_code_encoder_defines.svh */
// Assertion macros shared by the encoder RTL.
`ifndef ASCII_TO_SHIFT_CODE_ENCODER_DEFINES_SVH
`define ASCII_TO_SHIFT_CODE_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define ATSC_ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("atsc: check failed");
// Check that a condition implies another in the next cycle.
`define ATSC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("atsc: check failed");
`else
`define ATSC_ASSERT_ALWAYS(lbl, expr)
`define ATSC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* src/atsc_pkg.sv */
// Types, constants and the key table of the shift code encoder.
package atsc_pkg;

   localparam logic [6:0] KEY_RUBOUT     = 7'o177;
   localparam logic [6:0] KEY_BACKSPACE  = 7'o010;
   localparam logic [5:0] SHIFT_TO_UPPER = 6'o74;
   localparam logic [5:0] SHIFT_TO_LOWER = 6'o72;
   localparam int unsigned FLAG_UPPER_BIT = 6;
   localparam int unsigned FLAG_BOTH_BIT  = 7;

   // Entry: bit 7 both cases, bit 6 upper case, bits 5:0 character code.
   localparam logic [7:0] KEY_TABLE [128] = '{
      8'o000, 8'o000, 8'o000, 8'o000, 8'o000, 8'o000, 8'o000, 8'o000,
      8'o275, 8'o236, 8'o000, 8'o000, 8'o000, 8'o277, 8'o000, 8'o000,
      8'o000, 8'o000, 8'o000, 8'o000, 8'o000, 8'o000, 8'o000, 8'o000,
      8'o000, 8'o000, 8'o000, 8'o000, 8'o000, 8'o000, 8'o000, 8'o000,
      8'o200, 8'o105, 8'o101, 8'o104, 8'o000, 8'o000, 8'o106, 8'o102,
      8'o057, 8'o055, 8'o173, 8'o154, 8'o033, 8'o054, 8'o073, 8'o021,
      8'o020, 8'o001, 8'o002, 8'o003, 8'o004, 8'o005, 8'o006, 8'o007,
      8'o010, 8'o011, 8'o000, 8'o000, 8'o107, 8'o133, 8'o110, 8'o121,
      8'o040, 8'o161, 8'o162, 8'o163, 8'o164, 8'o165, 8'o166, 8'o167,
      8'o170, 8'o171, 8'o141, 8'o142, 8'o143, 8'o144, 8'o145, 8'o146,
      8'o147, 8'o150, 8'o151, 8'o122, 8'o123, 8'o124, 8'o125, 8'o126,
      8'o127, 8'o130, 8'o131, 8'o157, 8'o056, 8'o155, 8'o111, 8'o140,
      8'o120, 8'o061, 8'o062, 8'o063, 8'o064, 8'o065, 8'o066, 8'o067,
      8'o070, 8'o071, 8'o041, 8'o042, 8'o043, 8'o044, 8'o045, 8'o046,
      8'o047, 8'o050, 8'o051, 8'o022, 8'o023, 8'o024, 8'o025, 8'o026,
      8'o027, 8'o030, 8'o031, 8'o000, 8'o156, 8'o000, 8'o103, 8'o275
   };

   typedef struct packed {
      logic       hit;         // key translates to at least one item
      logic       swap;        // key needs a case shift first
      logic       want_upper;  // case the key belongs to
      logic [5:0] char_code;
      logic [5:0] shift_code;
   } atsc_dec_type;

endpackage

/* src/atsc_decode.sv */
// Key decode: mask, rubout mapping, table lookup and case decision.
module atsc_decode
   import atsc_pkg::*;
(
   input  logic [7:0]   key_byte,
   input  logic         upper_mode,
   output atsc_dec_type dec
);

   logic [6:0] key;
   logic [7:0] entry;

   always_comb begin
      key = key_byte[6:0];
      if (key == KEY_RUBOUT) begin
         key = KEY_BACKSPACE;
      end
      entry = KEY_TABLE[key];
      dec.hit        = (entry != 8'd0);
      dec.want_upper = entry[FLAG_UPPER_BIT];
      dec.swap       = dec.hit && !entry[FLAG_BOTH_BIT]
                       && (entry[FLAG_UPPER_BIT] != upper_mode);
      dec.char_code  = entry[5:0];
      dec.shift_code = entry[FLAG_UPPER_BIT] ? SHIFT_TO_UPPER : SHIFT_TO_LOWER;
   end

endmodule

/* src/ascii_to_shift_code_encoder.sv */
// Top level of the keyboard byte to six-bit case shift code encoder.
//
// Each accepted key byte is held in an input register, decoded in one pass
// (bit 7 dropped, rubout turned into backspace, 128-entry table lookup) and
// written to the result register. A key of either case, or of the current
// case, gives one item with last set; a key of the other case gives the shift
// code (074 upper, 072 lower, is_shift set) and then the character, and the
// block takes on the new case. Untranslatable keys give nothing. Items leave
// through the single result register; the character behind a shift code
// waits in a one-entry pending slot. A new key is taken in the same cycle
// as the held key advances, so keys flow at one per cycle without shifts
// while rsp_ready holds high. Reset puts the block in lower case.
module ascii_to_shift_code_encoder
   import atsc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_key_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [5:0] rsp_tape_code,
   output logic       rsp_is_shift,
   output logic       rsp_last
);

`include "ascii_to_shift_code_encoder_defines.svh"

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] key_ff, key_in;
   // Current case.
   logic       upper_ff, upper_in;
   // Result register.
   logic       out_valid_ff, out_valid_in;
   logic [5:0] out_code_ff, out_code_in;
   logic       out_shift_ff, out_shift_in;
   logic       out_last_ff, out_last_in;
   // Pending character behind a shift code.
   logic       pend_valid_ff, pend_valid_in;
   logic [5:0] pend_code_ff, pend_code_in;

   atsc_dec_type dec;
   logic         out_free;
   logic         in_adv;

   atsc_decode u_decode (
      .key_byte   (key_ff),
      .upper_mode (upper_ff),
      .dec        (dec)
   );

   // The result register frees up when empty or when its item is taken.
   assign out_free = !out_valid_ff || rsp_ready;
   // Drop untranslatable keys at once; advance others only with no pending item.
   assign in_adv    = in_valid_ff && (!dec.hit || (out_free && !pend_valid_ff));
   assign req_ready = !in_valid_ff || in_adv;

   always_comb begin
      in_valid_in   = in_valid_ff;
      key_in        = key_ff;
      upper_in      = upper_ff;
      out_valid_in  = out_valid_ff;
      out_code_in   = out_code_ff;
      out_shift_in  = out_shift_ff;
      out_last_in   = out_last_ff;
      pend_valid_in = pend_valid_ff;
      pend_code_in  = pend_code_ff;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      if (pend_valid_ff && out_free) begin
         // Move the pending character up behind its shift code.
         out_valid_in  = 1'b1;
         out_code_in   = pend_code_ff;
         out_shift_in  = 1'b0;
         out_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end else if (in_adv && dec.hit) begin
         out_valid_in = 1'b1;
         if (dec.swap) begin
            out_code_in   = dec.shift_code;
            out_shift_in  = 1'b1;
            out_last_in   = 1'b0;
            pend_valid_in = 1'b1;
            pend_code_in  = dec.char_code;
            upper_in      = dec.want_upper;
         end else begin
            out_code_in  = dec.char_code;
            out_shift_in = 1'b0;
            out_last_in  = 1'b1;
         end
      end

      if (in_adv) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         key_in      = req_key_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         upper_ff      <= 1'b0;
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         upper_ff      <= upper_in;
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
      key_ff       <= key_in;
      out_code_ff  <= out_code_in;
      out_shift_ff <= out_shift_in;
      out_last_ff  <= out_last_in;
      pend_code_ff <= pend_code_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_tape_code = out_code_ff;
   assign rsp_is_shift  = out_shift_ff;
   assign rsp_last      = out_last_ff;

   // A pending character only sits behind a shift code in the result register.
   `ATSC_ASSERT_ALWAYS(a_pend_behind_shift,
      !pend_valid_ff || (out_valid_ff && out_shift_ff))
   // A shift code is never the last item and is one of the two shift codes.
   `ATSC_ASSERT_ALWAYS(a_shift_form, !(out_valid_ff && out_shift_ff)
      || (!out_last_ff && (out_code_ff == SHIFT_TO_UPPER || out_code_ff == SHIFT_TO_LOWER)))
   // A taken shift code is followed at once by its character.
   `ATSC_ASSERT_NEXT(a_char_follows, out_valid_ff && out_shift_ff && rsp_ready,
      out_valid_ff && !out_shift_ff && out_last_ff)
   // The case changes only when a key with a case shift advances.
   `ATSC_ASSERT_NEXT(a_case_hold, !(in_adv && dec.swap), $stable(upper_ff))

endmodule
